### rtl/cbbp_pkg.sv
// Shared types and constants for the container block boundary parser.
// No dependencies; used by cbbp_rsp_queue and container_block_boundary_parser.
package cbbp_pkg;

   // record kinds
   localparam logic [1:0] KIND_BLOCK = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // register indexes
   localparam logic CSR_STORED_TYPE = 1'b0;
   localparam logic CSR_CODED_TYPE  = 1'b1;

   // result queue geometry
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_W       = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_CNT_W       = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] block_offset;
      logic [31:0] block_length;
      logic [31:0] raw_length;
      logic [31:0] blocks_found;
      logic        truncated;
      logic        run_end;
   } rsp_type;

   // up to two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } rsp_push_type;

endpackage

### rtl/cbbp_rsp_queue.sv
// Four-entry queue: up to two results in a cycle, one out unless rsp_stall.
// Depends on cbbp_pkg.
module cbbp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  cbbp_pkg::rsp_push_type push,
   output logic                   room_for_two,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cbbp_pkg::rsp_type      rsp_data
);

   cbbp_pkg::rsp_type                  entry_ff [cbbp_pkg::RSP_QUEUE_DEPTH];
   logic [cbbp_pkg::RSP_PTR_W-1:0]     head_ff, head_in;
   logic [cbbp_pkg::RSP_PTR_W-1:0]     tail_ff, tail_in;
   logic [cbbp_pkg::RSP_CNT_W-1:0]     count_ff, count_in;
   logic [cbbp_pkg::RSP_PTR_W-1:0]     tail_next;
   logic                               pop;

   assign rsp_valid    = (count_ff != '0);
   assign rsp_data     = entry_ff[head_ff];
   assign room_for_two = (count_ff <= cbbp_pkg::RSP_CNT_W'(cbbp_pkg::RSP_QUEUE_DEPTH - 2));
   assign pop          = rsp_valid && !rsp_stall;
   assign tail_next    = tail_ff + cbbp_pkg::RSP_PTR_W'(1);

   always_comb begin
      head_in  = pop ? head_ff + cbbp_pkg::RSP_PTR_W'(1) : head_ff;
      tail_in  = tail_ff + cbbp_pkg::RSP_PTR_W'(push.count);
      count_in = count_ff + cbbp_pkg::RSP_CNT_W'(push.count)
                 - cbbp_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_next] <= push.item1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) + 32'(push.count)) <= cbbp_pkg::RSP_QUEUE_DEPTH)
      else $error("result queue overflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= cbbp_pkg::RSP_QUEUE_DEPTH)
      else $error("result queue count out of range");
`endif

endmodule

### rtl/container_block_boundary_parser.sv
// Container block boundary parser: top level, parse state and its update.
// Depends on cbbp_pkg and cbbp_rsp_queue.
//
// Usage: the file is fed one byte per request on req_* (data byte plus an
// end-of-data mark on the final byte). Each accepted request updates the
// parse state in the same cycle and produces zero, one or two results,
// which enter a four-entry queue and leave on rsp_* one per cycle while
// rsp_stall is low. Throughput: one request per cycle; req_stall rises
// only when the result queue has fewer than two free entries, so a
// receiver that keeps rsp_stall low never slows the input. rsp_data.run_end
// marks the last result of a request. After the last block, an unknown
// block type or end of data the parser ignores further requests (still
// accepted) until reset. Reset (synchronous) empties the queue, clears the
// parse state and sets the type codes to stored 0 and coded 1. csr_* writes
// change them; the user writes them only while idle (block does not check).
module container_block_boundary_parser #(
   parameter int FILE_HEADER_BYTES = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbbp_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [1:0]        csr_write_data
);

   localparam logic [2:0] PH_HDR   = 3'd0;
   localparam logic [2:0] PH_FLAGS = 3'd1;
   localparam logic [2:0] PH_RAW   = 3'd2;
   localparam logic [2:0] PH_COMP  = 3'd3;
   localparam logic [2:0] PH_PAY   = 3'd4;
   localparam logic [2:0] PH_RESET = (FILE_HEADER_BYTES > 0) ? PH_HDR : PH_FLAGS;

   logic [1:0]  stored_code_ff;
   logic [1:0]  coded_code_ff;
   logic [31:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] shift_ff, shift_in;
   logic [1:0]  fcount_ff, fcount_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] raw_ff, raw_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] total_ff, total_in;
   logic        halted_ff, halted_in;

   logic                   req_acc;
   logic                   room_for_two;
   cbbp_pkg::rsp_push_type push;

   assign req_stall = !room_for_two;
   assign req_acc   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_code_ff <= 2'd0;
         coded_code_ff  <= 2'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            cbbp_pkg::CSR_STORED_TYPE: stored_code_ff <= csr_write_data;
            cbbp_pkg::CSR_CODED_TYPE:  coded_code_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [1:0]  t;
      logic [31:0] value;
      logic [31:0] len;
      logic [31:0] rem_dec;
      logic        finish;
      logic        fin_raw;
      cbbp_pkg::rsp_type r0;
      cbbp_pkg::rsp_type r1;
      logic [1:0]  n;

      b        = req_data.data_byte;
      t        = 2'd0;
      value    = {b, shift_ff[23:0]};
      len      = 32'd0;
      rem_dec  = remain_ff - 32'd1;
      finish   = 1'b0;
      fin_raw  = 1'b0;
      r0       = '0;
      r1       = '0;
      n        = 2'd0;

      pos_in    = pos_ff;
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      fcount_in = fcount_ff;
      flags_in  = flags_ff;
      start_in  = start_ff;
      raw_in    = raw_ff;
      remain_in = remain_ff;
      total_in  = total_ff;
      halted_in = halted_ff;

      if (req_acc && !halted_ff) begin
         pos_in = pos_ff + 32'd1;
         case (phase_ff)
            PH_HDR: begin
               if (pos_in >= 32'(FILE_HEADER_BYTES)) begin
                  phase_in = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               t        = b[2:1];
               flags_in = b;
               start_in = pos_ff;
               if (t == stored_code_ff || t == coded_code_ff) begin
                  phase_in  = PH_RAW;
                  shift_in  = 32'd0;
                  fcount_in = 2'd0;
               end else begin
                  r0.record_kind  = cbbp_pkg::KIND_ERROR;
                  r0.block_offset = pos_ff;
                  r0.blocks_found = total_ff;
                  n               = 2'd1;
                  halted_in       = 1'b1;
               end
            end
            PH_RAW, PH_COMP: begin
               if (fcount_ff == 2'd3) begin
                  fcount_in = 2'd0;
                  shift_in  = 32'd0;
                  if (phase_ff == PH_RAW) begin
                     raw_in = value;
                     if (flags_ff[2:1] == stored_code_ff) begin
                        finish  = 1'b1;
                        fin_raw = 1'b1;
                        len     = 32'd5 + value;
                     end else begin
                        phase_in = PH_COMP;
                     end
                  end else begin
                     finish = 1'b1;
                     len    = 32'd9 + value;
                  end
               end else begin
                  shift_in  = shift_ff | ({24'd0, b} << {fcount_ff, 3'b000});
                  fcount_in = fcount_ff + 2'd1;
               end
            end
            PH_PAY: begin
               remain_in = rem_dec;
               if (rem_dec == 32'd0) begin
                  phase_in = PH_FLAGS;
               end
            end
            default: begin
               phase_in = PH_FLAGS;
            end
         endcase

         // block header complete: record, then payload skip if the payload is nonempty
         if (finish) begin
            total_in        = total_ff + 32'd1;
            r0.record_kind  = cbbp_pkg::KIND_BLOCK;
            r0.block_offset = start_ff;
            r0.block_length = len;
            r0.raw_length   = fin_raw ? value : raw_ff;
            r0.blocks_found = total_in;
            n               = 2'd1;
            remain_in       = value;
            phase_in        = (value != 32'd0) ? PH_PAY : PH_FLAGS;
            if (flags_ff[0]) begin
               r1.record_kind  = cbbp_pkg::KIND_END;
               r1.blocks_found = total_in;
               n               = 2'd2;
               halted_in       = 1'b1;
            end
         end

         if (!halted_in && req_data.end_of_data) begin
            if (n == 2'd0) begin
               r0.record_kind  = cbbp_pkg::KIND_END;
               r0.blocks_found = total_in;
               r0.truncated    = (phase_in == PH_RAW || phase_in == PH_COMP);
               n               = 2'd1;
            end else begin
               r1.record_kind  = cbbp_pkg::KIND_END;
               r1.blocks_found = total_in;
               r1.truncated    = (phase_in == PH_RAW || phase_in == PH_COMP);
               n               = 2'd2;
            end
            halted_in = 1'b1;
         end

         // mark the last result of this request
         if (n == 2'd1) begin
            r0.run_end = 1'b1;
         end else if (n == 2'd2) begin
            r1.run_end = 1'b1;
         end
      end

      push.count = n;
      push.item0 = r0;
      push.item1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 32'd0;
         phase_ff  <= PH_RESET;
         shift_ff  <= 32'd0;
         fcount_ff <= 2'd0;
         flags_ff  <= 8'd0;
         start_ff  <= 32'd0;
         raw_ff    <= 32'd0;
         remain_ff <= 32'd0;
         total_ff  <= 32'd0;
         halted_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         shift_ff  <= shift_in;
         fcount_ff <= fcount_in;
         flags_ff  <= flags_in;
         start_ff  <= start_in;
         raw_ff    <= raw_in;
         remain_ff <= remain_in;
         total_ff  <= total_in;
         halted_ff <= halted_in;
      end
   end

   cbbp_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("parser left halted state without reset");
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (remain_ff != 32'd0))
      else $error("payload phase with nothing left to skip");
   a_fcount_phase: assert property (@(posedge clock) disable iff (reset)
      (fcount_ff != 2'd0) |-> (phase_ff == PH_RAW || phase_ff == PH_COMP))
      else $error("size byte count outside size phases");
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (push.count == 2'd0))
      else $error("results produced while halted");
`endif

endmodule
